/* design/sist_pkg.sv */
// shared types and constants for the sip invite server transaction block
package sist_pkg;

    localparam int unsigned TMR_W   = 16;
    localparam int unsigned LONG_W  = 22;
    localparam int unsigned CODE_W  = 10;
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned STATE_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_T1      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_T2      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_T4      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_RELIABLE = 2'd3;

    localparam logic [TMR_W-1:0] T1_RESET = 16'd500;
    localparam logic [TMR_W-1:0] T2_RESET = 16'd4000;
    localparam logic [TMR_W-1:0] T4_RESET = 16'd5000;

    typedef enum logic [STATE_W-1:0] {
        ST_IDLE       = 3'd0,
        ST_PROCEEDING = 3'd1,
        ST_COMPLETED  = 3'd2,
        ST_CONFIRMED  = 3'd3,
        ST_ACCEPTED   = 3'd4,
        ST_TERMINATED = 3'd5
    } t_txn_state;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_START    = 3'd1,
        CMD_RESPONSE = 3'd2,
        CMD_ACK      = 3'd3,
        CMD_RETRANS  = 3'd4,
        CMD_ABORT    = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [TMR_W-1:0] timer_t1;
        logic [TMR_W-1:0] timer_t2;
        logic [TMR_W-1:0] timer_t4;
        logic             link_reliable;
    } t_cfg;

    typedef struct packed {
        logic [STATE_W-1:0] state_now;
        logic               send_trying;
        logic               send_new;
        logic               send_last;
        logic               ok;
        logic               no_ack_timeout;
    } t_result;

    function automatic logic [TMR_W-1:0] nonzero(input logic [TMR_W-1:0] v);
        nonzero = (v == '0) ? TMR_W'(1) : v;
    endfunction

endpackage

/* design/sist_cfg_regs.sv */
// configuration register bank for the transaction timers and link type
module sist_cfg_regs
    import sist_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TMR_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timer_t1      <= T1_RESET;
            r_cfg.timer_t2      <= T2_RESET;
            r_cfg.timer_t4      <= T4_RESET;
            r_cfg.link_reliable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMER_T1:      r_cfg.timer_t1      <= i_cfg_data;
                CFG_TIMER_T2:      r_cfg.timer_t2      <= i_cfg_data;
                CFG_TIMER_T4:      r_cfg.timer_t4      <= i_cfg_data;
                CFG_LINK_RELIABLE: r_cfg.link_reliable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/sist_txn_fsm.sv */
// transaction state machine with timers g, h, i and l
module sist_txn_fsm
    import sist_pkg::*;
#(
    parameter int unsigned LONG_TIMER_FACTOR = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_cmd              i_cmd,
    input  logic [CODE_W-1:0] i_code,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    t_txn_state        r_state, n_state;
    logic [TMR_W-1:0]  r_g_count, n_g_count;
    logic [TMR_W-1:0]  r_g_int, n_g_int;
    logic [LONG_W-1:0] r_h_count, n_h_count;
    logic [TMR_W-1:0]  r_i_count, n_i_count;
    logic [LONG_W-1:0] r_l_count, n_l_count;

    logic [TMR_W-1:0]  w_t1_nz;
    logic [TMR_W-1:0]  w_t2_nz;
    logic [LONG_W-1:0] w_long;
    logic [TMR_W:0]    w_g_dbl;
    logic [TMR_W-1:0]  w_g_next;
    logic              w_g_exp, w_h_exp, w_i_exp, w_l_exp;
    logic              w_is_2xx, w_ge_300;

    assign w_t1_nz  = nonzero(i_cfg.timer_t1);
    assign w_t2_nz  = nonzero(i_cfg.timer_t2);
    assign w_long   = LONG_W'(32'(w_t1_nz) * LONG_TIMER_FACTOR);
    assign w_g_dbl  = {nonzero(r_g_int), 1'b0};
    assign w_g_next = (w_g_dbl > {1'b0, w_t2_nz}) ? w_t2_nz : w_g_dbl[TMR_W-1:0];

    // a count of one expires on this tick
    assign w_g_exp = (r_g_count == TMR_W'(1));
    assign w_h_exp = (r_h_count == LONG_W'(1));
    assign w_i_exp = (r_i_count == TMR_W'(1));
    assign w_l_exp = (r_l_count == LONG_W'(1));

    assign w_is_2xx = i_code inside {[10'd200:10'd299]};
    assign w_ge_300 = i_code inside {[10'd300:10'd1023]};

    always_comb begin
        n_state   = r_state;
        n_g_count = r_g_count;
        n_g_int   = r_g_int;
        n_h_count = r_h_count;
        n_i_count = r_i_count;
        n_l_count = r_l_count;
        o_result  = '0;
        case (i_cmd)
            CMD_TICK: begin
                if (r_g_count != '0) n_g_count = r_g_count - TMR_W'(1);
                if (r_h_count != '0) n_h_count = r_h_count - LONG_W'(1);
                if (r_i_count != '0) n_i_count = r_i_count - TMR_W'(1);
                if (r_l_count != '0) n_l_count = r_l_count - LONG_W'(1);
                if (r_state == ST_COMPLETED) begin
                    if (w_h_exp) begin
                        n_state = ST_TERMINATED;
                        o_result.no_ack_timeout = 1'b1;
                    end else if (w_g_exp) begin
                        n_g_int   = w_g_next;
                        n_g_count = w_g_next;
                        o_result.send_last = 1'b1;
                    end
                end else if ((r_state == ST_CONFIRMED && w_i_exp) ||
                             (r_state == ST_ACCEPTED && w_l_exp)) begin
                    n_state = ST_TERMINATED;
                end
            end
            CMD_START: begin
                if (r_state == ST_IDLE || r_state == ST_TERMINATED) begin
                    n_state   = ST_PROCEEDING;
                    n_g_count = '0;
                    n_g_int   = '0;
                    n_h_count = '0;
                    n_i_count = '0;
                    n_l_count = '0;
                    o_result.send_trying = 1'b1;
                end
            end
            CMD_RESPONSE: begin
                if (r_state == ST_PROCEEDING) begin
                    o_result.ok       = 1'b1;
                    o_result.send_new = 1'b1;
                    if (w_is_2xx) begin
                        n_state   = ST_ACCEPTED;
                        n_l_count = w_long;
                    end else if (w_ge_300) begin
                        n_state   = ST_COMPLETED;
                        n_h_count = w_long;
                        if (!i_cfg.link_reliable) begin
                            n_g_int   = w_t1_nz;
                            n_g_count = w_t1_nz;
                        end
                    end
                end else if (r_state == ST_ACCEPTED && w_is_2xx) begin
                    o_result.ok       = 1'b1;
                    o_result.send_new = 1'b1;
                end
            end
            CMD_ACK: begin
                if (r_state == ST_COMPLETED) begin
                    n_g_count = '0;
                    n_g_int   = '0;
                    n_h_count = '0;
                    if (i_cfg.link_reliable) begin
                        n_state = ST_TERMINATED;
                    end else begin
                        n_state   = ST_CONFIRMED;
                        n_i_count = nonzero(i_cfg.timer_t4);
                    end
                end else if (r_state == ST_ACCEPTED) begin
                    o_result.ok = 1'b1;
                end
            end
            CMD_RETRANS: begin
                if (r_state == ST_PROCEEDING || r_state == ST_COMPLETED) begin
                    o_result.send_last = 1'b1;
                end
            end
            CMD_ABORT: begin
                if (r_state != ST_IDLE) n_state = ST_TERMINATED;
            end
            default: ;
        endcase
        // entering terminated drops every timer
        if (n_state == ST_TERMINATED && r_state != ST_TERMINATED) begin
            n_g_count = '0;
            n_g_int   = '0;
            n_h_count = '0;
            n_i_count = '0;
            n_l_count = '0;
        end
        o_result.state_now = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_g_count <= '0;
            r_g_int   <= '0;
            r_h_count <= '0;
            r_i_count <= '0;
            r_l_count <= '0;
        end else if (i_fire) begin
            r_state   <= n_state;
            r_g_count <= n_g_count;
            r_g_int   <= n_g_int;
            r_h_count <= n_h_count;
            r_i_count <= n_i_count;
            r_l_count <= n_l_count;
        end
    end

endmodule

/* design/sip_invite_server_transaction_top.sv */
// top level of the sip invite server transaction block
//
//  channel  direction  handshake            payload
//  event    in         i_valid / o_ready    i_cmd, i_status_code
//  result   out        o_valid / i_ready    o_state_now and five flags
//  config   in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// one transaction per cycle sustained while the result channel is not stalled;
// the input register takes the transaction at the accepting edge and the result
// register takes its outcome when the transaction advances out of the input register
// the state and timer update sits in one short pass of the transaction fsm
// synchronous active-low reset returns to idle with all timers stopped and
// the configuration at its default values
// a stalled result holds in the output register; the input register keeps
// taking transactions as long as the result register can drain
module sip_invite_server_transaction_top
    import sist_pkg::*;
#(
    parameter int unsigned LONG_TIMER_FACTOR = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TMR_W-1:0]     i_cfg_data,
    // event channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [CODE_W-1:0]    i_status_code,
    // result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [STATE_W-1:0]   o_state_now,
    output logic                 o_send_trying,
    output logic                 o_send_new,
    output logic                 o_send_last,
    output logic                 o_ok,
    output logic                 o_no_ack_timeout
);

    t_cfg              w_cfg;
    t_result           w_result;
    t_result           r_out;
    logic              r_out_valid;
    logic              r_in_valid;
    logic [CMD_W-1:0]  r_in_cmd;
    logic [CODE_W-1:0] r_in_code;
    logic              w_advance;
    logic              w_accept;

    // the registered transaction moves on when the result slot is free or draining
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign w_accept  = i_valid && o_ready;

    sist_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    sist_txn_fsm #(
        .LONG_TIMER_FACTOR (LONG_TIMER_FACTOR)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_cmd    (t_cmd'(r_in_cmd)),
        .i_code   (r_in_code),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_cmd  <= i_cmd;
            r_in_code <= i_status_code;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_advance || (r_out_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_state_now      = r_out.state_now;
    assign o_send_trying    = r_out.send_trying;
    assign o_send_new       = r_out.send_new;
    assign o_send_last      = r_out.send_last;
    assign o_ok             = r_out.ok;
    assign o_no_ack_timeout = r_out.no_ack_timeout;

endmodule

/* design/sist_checker.sv */
// port-level checks for the transaction block and their bind
module sist_checker
    import sist_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [STATE_W-1:0] o_state_now,
    input logic               o_send_trying,
    input logic               o_send_new,
    input logic               o_ok,
    input logic               o_no_ack_timeout
);

    // reset empties the result slot
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // a trying response only comes with the move to proceeding
    a_trying_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_send_trying |-> o_state_now == ST_PROCEEDING)
        else $error("send_trying outside proceeding");

    // missing ack timeout always ends the transaction
    a_noack_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_ack_timeout |-> o_state_now == ST_TERMINATED && !o_ok)
        else $error("no_ack_timeout without terminated");

    a_new_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_send_new |-> o_ok &&
            (o_state_now == ST_PROCEEDING || o_state_now == ST_COMPLETED ||
             o_state_now == ST_ACCEPTED))
        else $error("send_new without accepted response");

endmodule

bind sip_invite_server_transaction_top sist_checker u_sist_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_state_now      (o_state_now),
    .o_send_trying    (o_send_trying),
    .o_send_new       (o_send_new),
    .o_ok             (o_ok),
    .o_no_ack_timeout (o_no_ack_timeout)
);
